[sv/bfba_pkg.sv]
// Shared constants, codes and control types for the best-fit block allocator.
package bfba_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_BITS   = $clog2(NUM_BLOCKS);
  localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);
  localparam int CFG_BITS   = 5;
  localparam int BLK_W      = 4;
  localparam int VAL_W      = 16;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef struct packed {
    logic accept;
    logic scan_en;
    logic mark_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;

endpackage

[sv/bfba_ctrl.sv]
// Sequencer for item acceptance, table scan, marking and result hand-off.
module bfba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            command_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bfba_pkg::cmd_t  cmd_o,
  input  bfba_pkg::sts_t  sts_i
);
  import bfba_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_MARK = 5'b00100,
    ST_DONE = 5'b01000,
    ST_WAIT = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q;
    cmd_o          = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = (command_i == CMD_ALLOC) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_MARK;
        end
      end
      ST_MARK: begin
        cmd_o.mark_en = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE, ST_WAIT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_WAIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_scan_to_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && sts_i.scan_done) |=> (state_q == ST_MARK))
    else $error("scan end did not lead to mark");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

endmodule

[sv/bfba_dp.sv]
// Size table, allocated marks, best-fit scan registers and result registers.
module bfba_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bfba_pkg::CFG_BITS-1:0] cfg_wdata_i,
  input  logic                          command_i,
  input  logic [bfba_pkg::BLK_W-1:0]    block_index_i,
  input  logic [bfba_pkg::VAL_W-1:0]    size_value_i,
  input  bfba_pkg::cmd_t                cmd_i,
  output bfba_pkg::sts_t                sts_o,
  output logic                          granted_o,
  output logic [bfba_pkg::BLK_W-1:0]    chosen_block_o,
  output logic [bfba_pkg::VAL_W-1:0]    chosen_size_o,
  output logic [bfba_pkg::VAL_W-1:0]    leftover_o
);
  import bfba_pkg::*;

  size_t                 mem_q [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] marks_q;
  logic [CFG_BITS-1:0]   biu_q;

  size_t req_q;
  cnt_t  cnt_q;
  cnt_t  lim_q;
  cnt_t  lim;
  logic  rd_vld_q;
  idx_t  rd_idx_q;
  size_t rd_data_q;
  logic  found_q;
  idx_t  best_idx_q;
  size_t best_size_q;
  size_t best_left_q;

  logic  granted_q;
  logic [BLK_W-1:0] chosen_block_q;
  logic [VAL_W-1:0] chosen_size_q;
  logic [VAL_W-1:0] leftover_q;

  logic  load_wr;
  logic  issue;
  logic  fit;
  logic  better;
  size_t left;
  idx_t  wr_idx;

  assign wr_idx  = IDX_BITS'(block_index_i);
  assign load_wr = cmd_i.accept && (command_i == CMD_LOAD)
                   && (int'(block_index_i) < NUM_BLOCKS);
  assign issue   = cmd_i.scan_en && (cnt_q < lim_q);
  assign left    = rd_data_q - req_q;
  assign fit     = !marks_q[rd_idx_q] && (rd_data_q >= req_q);
  assign better  = !found_q || (left < best_left_q);

  assign sts_o.scan_done = (cnt_q == lim_q) && !rd_vld_q;

  always_comb begin
    if (int'(biu_q) > NUM_BLOCKS) begin
      lim = CNT_BITS'(NUM_BLOCKS);
    end else begin
      lim = CNT_BITS'(biu_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      mem_q[wr_idx] <= SIZE_BITS'(size_value_i);
    end
    if (issue) begin
      rd_data_q <= mem_q[cnt_q[IDX_BITS-1:0]];
      rd_idx_q  <= cnt_q[IDX_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      biu_q    <= CFG_BITS'(16);
      marks_q  <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      cnt_q    <= '0;
      lim_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        biu_q <= cfg_wdata_i;
      end
      if (load_wr) begin
        marks_q[wr_idx] <= 1'b0;
      end
      if (cmd_i.mark_en && found_q) begin
        marks_q[best_idx_q] <= 1'b1;
      end
      rd_vld_q <= issue;
      if (cmd_i.accept) begin
        cnt_q   <= '0;
        lim_q   <= lim;
        found_q <= 1'b0;
      end else begin
        if (issue) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (rd_vld_q && fit && better) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q       <= SIZE_BITS'(size_value_i);
      best_idx_q  <= '0;
      best_size_q <= '0;
      best_left_q <= '0;
    end else if (rd_vld_q && fit && better) begin
      best_idx_q  <= rd_idx_q;
      best_size_q <= rd_data_q;
      best_left_q <= left;
    end
    if (cmd_i.out_load) begin
      granted_q      <= found_q;
      chosen_block_q <= BLK_W'(best_idx_q);
      chosen_size_q  <= VAL_W'(best_size_q);
      leftover_q     <= VAL_W'(best_left_q);
    end
  end

  assign granted_o      = granted_q;
  assign chosen_block_o = chosen_block_q;
  assign chosen_size_o  = chosen_size_q;
  assign leftover_o     = leftover_q;

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (CNT_BITS'(rd_idx_q) < lim_q))
    else $error("scan read beyond blocks in use");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(NUM_BLOCKS))
    else $error("scan counter past table");

  a_mark_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mark_en && found_q) |=> marks_q[$past(best_idx_q)])
    else $error("chosen block not marked");

endmodule

[sv/best_fit_block_allocator_unit.sv]
// Top level of the best-fit block allocator: controller plus datapath.
// A load goes from acceptance straight to the result registers; an allocate scans the first N
// table entries, one table read a cycle, then marks the chosen block, if any, then loads the
// result registers; N = blocks in use capped at 16. One item is in flight at a time, and the
// next is taken while a result waits in the output.
// Reset frees every block, sets blocks in use to 16; sizes are unset.
module best_fit_block_allocator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bfba_pkg::CFG_BITS-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [bfba_pkg::BLK_W-1:0]    block_index_i,
  input  logic [bfba_pkg::VAL_W-1:0]    size_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          granted_o,
  output logic [bfba_pkg::BLK_W-1:0]    chosen_block_o,
  output logic [bfba_pkg::VAL_W-1:0]    chosen_size_o,
  output logic [bfba_pkg::VAL_W-1:0]    leftover_o
);
  import bfba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bfba_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .command_i      (command_i),
    .block_index_i  (block_index_i),
    .size_value_i   (size_value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .granted_o      (granted_o),
    .chosen_block_o (chosen_block_o),
    .chosen_size_o  (chosen_size_o),
    .leftover_o     (leftover_o)
  );

endmodule

[tb/tb.sv]
// Testbench for the best-fit block allocator: directed and random items against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfba_pkg::*;

  localparam int DRAIN_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;

  typedef struct packed {
    logic granted;
    idx_t blk;
    size_t size;
    size_t left;
  } grant_t;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                cfg_we       = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata    = CFG_BITS'(16);
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic                command      = CMD_LOAD;
  logic [BLK_W-1:0]    block_index  = '0;
  logic [VAL_W-1:0]    size_value   = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic                granted;
  logic [BLK_W-1:0]    chosen_block;
  logic [VAL_W-1:0]    chosen_size;
  logic [VAL_W-1:0]    leftover;

  size_t               table_size [NUM_BLOCKS];
  logic                taken      [NUM_BLOCKS];
  logic [CFG_BITS-1:0] in_use_cfg = CFG_BITS'(16);
  grant_t              pending_grants [$];
  int                  mismatch_cnt   = 0;
  int                  idle_cycles    = 0;
  int                  rx_hold_cycles = 0;
  bit                  tx_idle        = 1'b1;
  bit                  rx_idle        = 1'b1;

  best_fit_block_allocator_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .block_index_i  (block_index),
    .size_value_i   (size_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .granted_o      (granted),
    .chosen_block_o (chosen_block),
    .chosen_size_o  (chosen_size),
    .leftover_o     (leftover)
  );

  always #1 clk = ~clk;

  function automatic grant_t predict_grant(logic cmd, idx_t idx, size_t val);
    grant_t res;
    int     span;
    logic   hit;
    size_t  best_left;
    res = '0;
    hit = 1'b0;
    best_left = '0;
    if (cmd == CMD_LOAD) begin
      if (int'(idx) < NUM_BLOCKS) begin
        table_size[idx] = val;
        taken[idx] = 1'b0;
      end
      return res;
    end
    span = (int'(in_use_cfg) > NUM_BLOCKS) ? NUM_BLOCKS : int'(in_use_cfg);
    for (int j = 0; j < span; j++) begin
      if (!taken[j] && table_size[j] >= val &&
          (!hit || table_size[j] - val < best_left)) begin
        hit = 1'b1;
        res.blk = idx_t'(j);
        best_left = table_size[j] - val;
      end
    end
    if (hit) begin
      taken[res.blk] = 1'b1;
      res.granted = 1'b1;
      res.size = table_size[res.blk];
      res.left = best_left;
    end
    return res;
  endfunction

  function automatic size_t pick_block_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return size_t'($urandom);
      default: return size_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic size_t pick_request();
    size_t base;
    base = table_size[$urandom_range(0, NUM_BLOCKS - 1)];
    case ($urandom_range(0, 9))
      0, 1, 2: return base;
      3, 4: return base - size_t'($urandom_range(0, 8));
      5: return base + 1'b1;
      6: return size_t'($urandom);
      default: return size_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(input logic cmd, input idx_t idx, input size_t val);
    int gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    block_index <= idx;
    size_value  <= val;
    do @(posedge clk); while (in_stall);
    pending_grants.push_back(predict_grant(cmd, idx, val));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_blocks_in_use(input logic [CFG_BITS-1:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we     <= 1'b0;
    in_use_cfg = v;
  endtask

  task automatic test_zero_in_use();
    set_blocks_in_use('0);
    send_item(CMD_ALLOC, '0, '0);
    set_blocks_in_use(CFG_BITS'(NUM_BLOCKS));
  endtask

  task automatic test_table_basics();
    size_t sizes [NUM_BLOCKS];
    sizes = '{100, 50, 65535, 50, 0, 300, 7, 1000, 20, 20, 4096, 150, 75, 32768, 9, 65534};
    for (int i = 0; i < NUM_BLOCKS; i++) send_item(CMD_LOAD, idx_t'(i), sizes[i]);
    send_item(CMD_ALLOC, '1, 16'd50);
    send_item(CMD_ALLOC, '0, 16'd50);
    send_item(CMD_ALLOC, '1, 16'd0);
    send_item(CMD_ALLOC, '0, 16'hFFFF);
    send_item(CMD_ALLOC, '1, 16'hFFFF);
    send_item(CMD_ALLOC, '0, 16'd21);
    send_item(CMD_LOAD, idx_t'(2), 16'hFFFF);
    send_item(CMD_ALLOC, '1, 16'hFFFF);
  endtask

  task automatic test_block_counts();
    logic [CFG_BITS-1:0] counts [4];
    counts = '{CFG_BITS'(1), CFG_BITS'(17), '1, CFG_BITS'(9)};
    foreach (counts[k]) begin
      set_blocks_in_use(counts[k]);
      for (int i = 0; i < 8; i++) begin
        if (i % 4 == 3) send_item(CMD_LOAD, idx_t'($urandom), pick_block_size());
        else send_item(CMD_ALLOC, idx_t'($urandom), pick_request());
      end
    end
    set_blocks_in_use(CFG_BITS'(NUM_BLOCKS));
  endtask

  task automatic test_long_hold();
    drain_results();
    tx_idle = 1'b0;
    rx_hold_cycles = LONG_HOLD;
    for (int i = 0; i < 30; i++) begin
      if (i % 2 == 0) send_item(CMD_LOAD, idx_t'($urandom), pick_block_size());
      else send_item(CMD_ALLOC, idx_t'($urandom), pick_request());
    end
    drain_results();
    tx_idle = 1'b1;
  endtask

  task automatic test_random(input int count);
    logic [CFG_BITS-1:0] v;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      if (i % 250 == 249) begin
        case ($urandom_range(0, 7))
          0: v = '0;
          1: v = CFG_BITS'(1);
          2: v = '1;
          3: v = CFG_BITS'($urandom_range(17, 30));
          4: v = CFG_BITS'($urandom_range(2, 15));
          default: v = CFG_BITS'(NUM_BLOCKS);
        endcase
        set_blocks_in_use(v);
      end else if (i % 97 == 96) begin
        drain_results();
      end
      if ($urandom_range(0, 9) < 4) send_item(CMD_LOAD, idx_t'($urandom), pick_block_size());
      else send_item(CMD_ALLOC, idx_t'($urandom), pick_request());
    end
  endtask

  initial begin : rx_stall_gen
    int n;
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        n = rx_idle ? $urandom_range(0, 6) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && rx_hold_cycles == 0);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    grant_t seen;
    grant_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = {granted, chosen_block, chosen_size, leftover};
      if (pending_grants.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: granted=%0d block=%0d size=%0d leftover=%0d",
                   seen.granted, seen.blk, seen.size, seen.left);
      end else begin
        want = pending_grants.pop_front();
        if (seen.granted !== want.granted || seen.blk !== want.blk ||
            seen.size !== want.size || seen.left !== want.left) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: expected granted=%0d block=%0d size=%0d leftover=%0d",
                     want.granted, want.blk, want.size, want.left);
            $display("          got granted=%0d block=%0d size=%0d leftover=%0d",
                     seen.granted, seen.blk, seen.size, seen.left);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    foreach (taken[i]) begin
      taken[i] = 1'b0;
      table_size[i] = '0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_zero_in_use();
    test_table_basics();
    test_block_counts();
    test_long_hold();
    test_random(1560);
    drain_results();
    repeat (16) @(negedge clk);
    if (mismatch_cnt == 0 && pending_grants.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
